[sv/sle_pkg.sv]
package sle_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int POS_W  = 5;
    localparam int CNT_W  = 5;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MAX = 2'd1,
        OP_DEL_MIN = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic                     ins_en;
        logic                     pop_front;
        logic signed [DATA_W-1:0] ins_val;
    } cell_cmd_t;

endpackage

[sv/sle_cell.sv]
module sle_cell
    import sle_pkg::*;
(
    input  logic                     aclk,
    input  cell_cmd_t                cmd,
    input  logic                     occupied,
    input  logic                     prev_lt,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] right_value,
    output logic                     lt,
    output logic signed [DATA_W-1:0] value
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    assign lt    = occupied && (value_reg < cmd.ins_val);
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (cmd.ins_en && !lt) begin
            value_next = prev_lt ? cmd.ins_val : left_value;
        end else if (cmd.pop_front) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

[sv/sorted_list_engine_unit.sv]
// Sorted list engine: keeps up to CAPACITY signed 32-bit values in ascending
// order in a row of cells, each cell holding one value and trading it with
// its neighbors when the row shifts.
// Request channel (s_valid/s_ready): s_opcode selects insert, delete largest,
// delete smallest or read at 1-based s_position; s_value is the insert value.
// Result channel (m_valid/m_ready): one result per request carrying m_status
// (ok, empty, full, bad position), m_result_value and m_entry_count, the
// number of stored values after the request.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle unless stalled; every cell compares and
// shifts in the same cycle; the result register frees once it is taken.
// Stall: while m_valid is high and m_ready is low the result holds and
// s_ready is low, so no request is lost.
// Reset: aresetn (synchronous, active low) empties the list and drops any
// pending result; cell contents are not cleared, only the count.
module sorted_list_engine_unit
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_opcode,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic [POS_W-1:0]         s_position,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [ST_W-1:0]          m_status,
    output logic signed [DATA_W-1:0] m_result_value,
    output logic [CNT_W-1:0]         m_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     m_valid_reg;
    logic [ST_W-1:0]          status_reg;
    logic [ST_W-1:0]          status_next;
    logic signed [DATA_W-1:0] result_reg;
    logic signed [DATA_W-1:0] result_next;
    logic [CNT_W-1:0]         ecount_reg;

    logic                     accept;
    logic                     empty;
    logic                     full;
    logic                     bad_pos;
    op_t                      op;
    logic [PW-1:0]            pos_w;
    logic [PW-1:0]            count_w;
    logic [PW-1:0]            sel_w;
    logic signed [DATA_W-1:0] sel_value;
    cell_cmd_t                cmd;

    logic                     cell_lt    [CAPACITY];
    logic signed [DATA_W-1:0] cell_value [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign op      = op_t'(s_opcode);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(CAPACITY));
    assign pos_w   = PW'(s_position);
    assign count_w = PW'(count_reg);
    assign bad_pos = (pos_w == '0) || (pos_w > count_w);
    assign sel_w   = (op == OP_READ) ? pos_w : count_w;

    always_comb begin
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (PW'(i + 1) == sel_w) begin
                sel_value = sel_value | cell_value[i];
            end
        end
    end

    always_comb begin
        cmd.ins_en    = accept && (op == OP_INSERT) && !full;
        cmd.pop_front = accept && (op == OP_DEL_MIN) && !empty;
        cmd.ins_val   = s_value;
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic                     prev_lt;
            logic signed [DATA_W-1:0] left_value;
            logic signed [DATA_W-1:0] right_value;

            if (g == 0) begin : g_first
                assign prev_lt    = 1'b1;
                assign left_value = s_value;
            end else begin : g_mid
                assign prev_lt    = cell_lt[g-1];
                assign left_value = cell_value[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign right_value = cell_value[g];
            end else begin : g_inner
                assign right_value = cell_value[g+1];
            end

            sle_cell u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .occupied    (CW'(g) < count_reg),
                .prev_lt     (prev_lt),
                .left_value  (left_value),
                .right_value (right_value),
                .lt          (cell_lt[g]),
                .value       (cell_value[g])
            );
        end
    endgenerate

    always_comb begin
        status_next = ST_OK;
        result_next = '0;
        count_next  = count_reg;
        unique case (op)
            OP_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEL_MAX: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    result_next = sel_value;
                    count_next  = count_reg - 1'b1;
                end
            end
            OP_DEL_MIN: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    result_next = cell_value[0];
                    count_next  = count_reg - 1'b1;
                end
            end
            OP_READ: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (bad_pos) begin
                    status_next = ST_BADPOS;
                end else begin
                    result_next = sel_value;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            result_reg <= result_next;
            ecount_reg <= CNT_W'(count_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_result_value = result_reg;
    assign m_entry_count  = ecount_reg;

endmodule

[sv/sle_checker.sv]
module sle_checker
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [ST_W-1:0]          m_status,
    input logic signed [DATA_W-1:0] m_result_value,
    input logic [CNT_W-1:0]         m_entry_count
);

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("request accepted without a result");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_result_value) && $stable(m_entry_count))
        else $error("stalled result changed");

    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_result_value == '0)
        else $error("nonzero value on failed request");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |-> m_entry_count == '0)
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> m_entry_count == CNT_W'(CAPACITY))
        else $error("full status with wrong count");

endmodule

bind sorted_list_engine_unit sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (.*);
